FILE: hdl/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
package lpht_pkg;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_DELETE = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_TOMB  = 2'd2,
      SLOT_RSVD  = 2'd3
   } slot_state_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic load;        // capture request, start hash
      logic hash_step;   // one FNV byte step
      logic probe_start; // set probe pointer to home slot
      logic probe_next;  // advance probe pointer
      logic write_used;  // write entry into current slot
      logic write_tomb;  // mark current slot as tombstone
      logic capture_hit; // latch found value
   } lpht_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic hash_done;
      logic full;
      logic slot_empty;
      logic slot_free;
      logic slot_match;
      logic probe_last;
   } lpht_stat_type;

endpackage

FILE: hdl/linear_probe_hash_table.sv
// Top level of the linear probing hash table.
// One request is taken when start is high and busy is low. The key is hashed one byte per
// cycle, with key_length capped at KEY_BYTES_MAX; then slots are probed one per cycle
// starting at the home slot, until the request resolves or every slot has been probed.
// An insert into a full table skips probing and reports full. The response
// appears for one cycle under rsp_valid and cannot be stalled.
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS   = 16,
   parameter int KEY_BYTES_MAX = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_length,
   input  logic [31:0] req_insert_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_value
);

   lpht_cmd_type  cmd;
   lpht_stat_type stat;

   lpht_control u_ctrl (
      .clock, .reset, .start, .req_opcode, .busy, .cmd, .stat,
      .rsp_valid, .rsp_status
   );

   lpht_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BYTES_MAX(KEY_BYTES_MAX)) u_dp (
      .clock, .reset, .cmd, .stat, .req_key_bytes, .req_key_length,
      .req_insert_value, .hit_value(rsp_found_value)
   );

endmodule

FILE: hdl/lpht_datapath.sv
// Datapath: request registers, FNV-1a hash unit, slot storage and probe pointer.
module lpht_datapath
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS   = 16,
   parameter int KEY_BYTES_MAX = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lpht_cmd_type         cmd,
   output lpht_stat_type        stat,
   input  logic [63:0]          req_key_bytes,
   input  logic [3:0]           req_key_length,
   input  logic [31:0]          req_insert_value,
   output logic [31:0]          hit_value
);

   localparam int SW = $clog2(TABLE_SLOTS);
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam logic [3:0] LEN_MAX = 4'(KEY_BYTES_MAX);

   logic [63:0] key_ff;
   logic [3:0]  len_ff;
   logic [31:0] val_ff;
   logic [31:0] hash_ff;
   logic [3:0]  hcnt_ff;
   logic [SW-1:0] ptr_ff;
   logic [SW-1:0] pcnt_ff;
   logic [CW-1:0] count_ff;
   logic [31:0] hit_ff;

   logic [1:0]  status_ff [TABLE_SLOTS];
   logic [63:0] skey_mem  [TABLE_SLOTS];
   logic [3:0]  slen_mem  [TABLE_SLOTS];
   logic [31:0] sval_mem  [TABLE_SLOTS];

   logic [3:0]  len_in;
   logic [63:0] key_in;
   logic [63:0] mask;
   logic [7:0]  hbyte;

   always_comb begin
      len_in = (req_key_length > LEN_MAX) ? LEN_MAX : req_key_length;
      mask = '0;
      for (int b = 0; b < 8; b++) begin
         if (4'(b) < len_in) mask[8*b +: 8] = 8'hFF;
      end
      key_in = req_key_bytes & mask;
      hbyte = key_ff[8*hcnt_ff[2:0] +: 8];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff  <= key_in;
         len_ff  <= len_in;
         val_ff  <= req_insert_value;
         hash_ff <= FNV_BASIS;
         hcnt_ff <= '0;
      end else if (cmd.hash_step) begin
         hash_ff <= (hash_ff ^ {24'd0, hbyte}) * FNV_PRIME;
         hcnt_ff <= hcnt_ff + 4'd1;
      end
      if (cmd.probe_start) begin
         ptr_ff  <= hash_ff[SW-1:0];
         pcnt_ff <= '0;
      end else if (cmd.probe_next) begin
         ptr_ff  <= ptr_ff + 1'b1;
         pcnt_ff <= pcnt_ff + 1'b1;
      end
      if (cmd.write_used) begin
         skey_mem[ptr_ff] <= key_ff;
         slen_mem[ptr_ff] <= len_ff;
         sval_mem[ptr_ff] <= val_ff;
      end
      if (cmd.load) hit_ff <= '0;
      else if (cmd.capture_hit) hit_ff <= sval_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < TABLE_SLOTS; i++) status_ff[i] <= SLOT_EMPTY;
      end else begin
         if (cmd.write_used) begin
            status_ff[ptr_ff] <= SLOT_USED;
            count_ff <= count_ff + 1'b1;
         end else if (cmd.write_tomb) begin
            status_ff[ptr_ff] <= SLOT_TOMB;
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_comb begin
      stat.hash_done  = (hcnt_ff == len_ff);
      stat.full       = (count_ff == CW'(TABLE_SLOTS));
      stat.slot_empty = (status_ff[ptr_ff] == SLOT_EMPTY);
      stat.slot_free  = (status_ff[ptr_ff] != SLOT_USED);
      stat.slot_match = (status_ff[ptr_ff] == SLOT_USED) && (slen_mem[ptr_ff] == len_ff)
                        && (skey_mem[ptr_ff] == key_ff);
      stat.probe_last = (pcnt_ff == SW'(TABLE_SLOTS - 1));
   end

   assign hit_value = hit_ff;

endmodule

FILE: hdl/lpht_control.sv
// Controller: sequences hashing, probing and the response strobe.
module lpht_control
   import lpht_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_opcode,
   output logic          busy,
   output lpht_cmd_type  cmd,
   input  lpht_stat_type stat,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status
);

   typedef enum logic [2:0] {
      S_IDLE, S_HASH, S_PROBE, S_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [1:0]  st_ff, st_in;
   logic        busy_ff, busy_in;
   logic        valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      st_in    = st_ff;
      busy_in  = busy_ff;
      valid_in = 1'b0;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_opcode;
               busy_in  = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (stat.hash_done) begin
               cmd.probe_start = 1'b1;
               state_in = S_PROBE;
               if (op_ff == OP_INSERT && stat.full) begin
                  st_in = ST_FULL;
                  state_in = S_DONE;
               end else if (op_ff == OP_NONE) begin
                  st_in = ST_MISS;
                  state_in = S_DONE;
               end
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         S_PROBE: begin
            cmd.probe_next = 1'b1;
            if (op_ff == OP_INSERT && stat.slot_free) begin
               cmd.write_used = 1'b1;
               st_in = ST_OK;
               state_in = S_DONE;
            end else if (op_ff == OP_LOOKUP && stat.slot_empty) begin
               st_in = ST_MISS;
               state_in = S_DONE;
            end else if (op_ff != OP_INSERT && stat.slot_match) begin
               cmd.capture_hit = (op_ff == OP_LOOKUP);
               cmd.write_tomb  = (op_ff == OP_DELETE);
               st_in = ST_OK;
               state_in = S_DONE;
            end else if (stat.probe_last) begin
               st_in = ST_MISS;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            valid_in = 1'b1;
            busy_in  = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         op_ff    <= OP_NONE;
         st_ff    <= ST_MISS;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         op_ff    <= op_in;
         st_ff    <= st_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_valid  = valid_ff;
   assign rsp_status = st_ff;

   a_busy_in_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !busy_ff) else $error("busy set while idle");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write_used && cmd.write_tomb)) else $error("two slot writes at once");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe held");
   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid && !busy) else $error("missing response");

endmodule
